/* design/greedy_first_fit_coloring_defines.svh */
// ---------------------------------------------------------------------------
// greedy first-fit colouring: assertion macros
// shared assertion forms, clocked on aclk and quiet while aresetn is low
// ---------------------------------------------------------------------------
`ifndef GREEDY_FIRST_FIT_COLORING_DEFINES_SVH
`define GREEDY_FIRST_FIT_COLORING_DEFINES_SVH

// same-cycle implication
`define GFFC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GFFC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/gffc_pkg.sv */
// ---------------------------------------------------------------------------
// gffc_pkg
// constants and types for the greedy first-fit colouring block
// ---------------------------------------------------------------------------
package gffc_pkg;

    // default sizes
    localparam int unsigned MAX_NODES_DEF  = 1024;
    localparam int unsigned MAX_COLORS_DEF = 32;

    // fixed field widths
    localparam int unsigned NB_W      = 10;
    localparam int unsigned OUT_NODE_W = 10;
    localparam int unsigned OUT_COL_W  = 5;
    localparam int unsigned OUT_USED_W = 6;

    // stream word widths
    localparam int unsigned S_TDATA_W = 16;
    localparam int unsigned S_TUSER_W = 2;
    localparam int unsigned M_TDATA_W = 24;

    // s_tuser bit positions
    localparam int unsigned S_USER_NEW_GRAPH = 0;
    localparam int unsigned S_USER_HAS_NB    = 1;

    // one input word held in the working stage
    typedef struct packed {
        logic            new_graph;
        logic            has_neighbor;
        logic [NB_W-1:0] neighbor_index;
        logic            last_of_node;
    } item_t;

endpackage

/* design/greedy_first_fit_coloring.sv */
// ---------------------------------------------------------------------------
// greedy_first_fit_coloring
// colours graph nodes in index order with the lowest colour not used by any
// lower-numbered neighbour
// ---------------------------------------------------------------------------
// Usage: for each node in turn, stream one word per neighbour (row and column
// neighbours alike) on the s_ channel; tuser flags new_graph and has_neighbor,
// tdata carries the neighbour index, tlast marks the final word of the node.
// A node without neighbours is one word with has_neighbor low and tlast high.
// Only neighbours below the current node count. Each tlast word yields one
// m_ word: node index, colour, colours used so far, and an overflow flag in
// tuser when every colour was taken (colour then saturates at the top value).
// Timing: a word is registered on acceptance while the colour table read is
// launched; the working stage then folds the colour into the blocked set and,
// on tlast, picks the colour and loads the output register, unless a pending
// result holds it. One word per cycle is sustained while results are taken,
// set by one colour table read per word, with a bypass for the node
// written in the same cycle.
// Reset clears node count, colour count, blocked set and both valid flags;
// the colour table is not cleared and only entries already written count.
// While m_tready is low a pending result holds, and s_tready drops only when
// the word in the working stage is a tlast word that cannot be delivered.
// ---------------------------------------------------------------------------
`include "greedy_first_fit_coloring_defines.svh"

module greedy_first_fit_coloring
    import gffc_pkg::*;
#(
    parameter int unsigned MAX_NODES  = MAX_NODES_DEF,
    parameter int unsigned MAX_COLORS = MAX_COLORS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [9:0] neighbor_index, rest zero
    input  logic [S_TUSER_W-1:0] s_tuser,   // [0] new_graph, [1] has_neighbor
    input  logic                 s_tlast,   // last_of_node
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [9:0] node_index, [14:10] node_color,
                                            // [20:15] colors_used, rest zero
    output logic                 m_tuser    // color_overflow
);

    localparam int unsigned NODE_W  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int unsigned COLOR_W = (MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1;
    localparam int unsigned CMP_W   = (NODE_W > NB_W) ? NODE_W : NB_W;

    // colour table
    logic [COLOR_W-1:0] color_mem [MAX_NODES];

    // working stage
    item_t              item_reg;
    logic               item_valid_reg;
    logic [COLOR_W-1:0] rd_data_reg;
    logic               fwd_hit_reg;
    logic [COLOR_W-1:0] fwd_data_reg;

    // colouring state
    logic [MAX_COLORS-1:0] blocked_reg, blocked_next;
    logic [NODE_W-1:0]     node_reg, node_next;
    logic [COLOR_W-1:0]    highest_reg, highest_next;

    // output register
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 m_tuser_reg;

    // working-stage logic
    logic                  s_accept;
    logic                  s1_adv;
    logic                  s1_fire;
    logic                  s1_emit;
    logic [NODE_W-1:0]     node_eff;
    logic [COLOR_W-1:0]    highest_eff;
    logic [COLOR_W-1:0]    nb_color;
    logic                  nb_counts;
    logic [MAX_COLORS-1:0] blocked_eff;
    logic [COLOR_W-1:0]    pick;
    logic                  overflow;
    logic [NODE_W-1:0]     rd_addr;
    logic [M_TDATA_W-1:0]  result_word;

    // handshake
    assign s1_adv   = !item_reg.last_of_node || !m_tvalid_reg || m_tready;
    assign s1_fire  = item_valid_reg && s1_adv;
    assign s1_emit  = s1_fire && item_reg.last_of_node;
    assign s_tready = !item_valid_reg || s1_adv;
    assign s_accept = s_tvalid && s_tready;
    assign rd_addr  = NODE_W'(s_tdata[NB_W-1:0]);

    // blocked set update and first-fit pick
    always_comb begin
        node_eff    = item_reg.new_graph ? '0 : node_reg;
        highest_eff = item_reg.new_graph ? '0 : highest_reg;
        nb_color    = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
        nb_counts   = item_reg.has_neighbor
                      && (CMP_W'(item_reg.neighbor_index) < CMP_W'(node_eff))
                      && ({1'b0, nb_color} < (COLOR_W+1)'(MAX_COLORS));
        blocked_eff = item_reg.new_graph ? '0 : blocked_reg;
        if (nb_counts) begin
            blocked_eff = blocked_eff | (MAX_COLORS'(1) << nb_color);
        end
        pick     = COLOR_W'(MAX_COLORS - 1);
        overflow = 1'b1;
        for (int i = MAX_COLORS - 1; i >= 0; i--) begin
            if (!blocked_eff[i]) begin
                pick     = COLOR_W'(i);
                overflow = 1'b0;
            end
        end
        // next state
        if (item_reg.last_of_node) begin
            blocked_next = '0;
            highest_next = (pick > highest_eff) ? pick : highest_eff;
            node_next    = (node_eff == NODE_W'(MAX_NODES - 1)) ? '0 : node_eff + 1'b1;
        end else begin
            blocked_next = blocked_eff;
            highest_next = highest_eff;
            node_next    = node_eff;
        end
        result_word = '0;
        result_word[OUT_NODE_W-1:0] = OUT_NODE_W'(node_eff);
        result_word[OUT_NODE_W +: OUT_COL_W] = OUT_COL_W'(pick);
        result_word[OUT_NODE_W+OUT_COL_W +: OUT_USED_W] =
            OUT_USED_W'((COLOR_W+1)'(highest_next) + 1'b1);
    end

    // colour table write and read, with bypass of a same-cycle write
    always_ff @(posedge aclk) begin
        if (s1_emit) begin
            color_mem[node_eff] <= pick;
        end
        if (s_accept) begin
            rd_data_reg  <= color_mem[rd_addr];
            fwd_data_reg <= pick;
        end
    end

    // working stage and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
            fwd_hit_reg    <= 1'b0;
            blocked_reg    <= '0;
            node_reg       <= '0;
            highest_reg    <= '0;
        end else begin
            if (s_accept) begin
                item_valid_reg <= 1'b1;
                fwd_hit_reg    <= s1_emit && (node_eff == rd_addr);
            end else if (s1_fire) begin
                item_valid_reg <= 1'b0;
            end
            if (s1_fire) begin
                blocked_reg <= blocked_next;
                node_reg    <= node_next;
                highest_reg <= highest_next;
            end
        end
    end

    // input word capture
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            item_reg.new_graph      <= s_tuser[S_USER_NEW_GRAPH];
            item_reg.has_neighbor   <= s_tuser[S_USER_HAS_NB];
            item_reg.neighbor_index <= s_tdata[NB_W-1:0];
            item_reg.last_of_node   <= s_tlast;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s1_emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_emit) begin
            m_tdata_reg <= result_word;
            m_tuser_reg <= overflow;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // checks
    `GFFC_ASSERT_NOW(a_pick_free, s1_emit && !overflow, !blocked_eff[pick],
                     "picked colour is blocked")
    `GFFC_ASSERT_NOW(a_overflow_full, s1_emit && overflow,
                     (&blocked_eff) && (pick == COLOR_W'(MAX_COLORS - 1)),
                     "overflow without full blocked set")
    `GFFC_ASSERT_NOW(a_highest_mono, s1_emit, highest_next >= pick,
                     "colour count below picked colour")
    `GFFC_ASSERT_NEXT(a_bypass_hit, s_accept && s1_emit && (node_eff == rd_addr),
                      fwd_hit_reg && (fwd_data_reg == $past(pick)),
                      "missed bypass of colour write")

endmodule

/* bench/greedy_first_fit_coloring_checker.sv */
// ----------------------------------------------------------------------------
// greedy first-fit colouring checker
// Watches both stream channels of the colouring block. Every accepted input
// word goes through a local colouring model that keeps its own colour table,
// blocked set, node counter and colour count. Each result word is compared
// field by field with the oldest predicted colouring.
// ----------------------------------------------------------------------------
module greedy_first_fit_coloring_checker
    import gffc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [9:0] neighbor_index, rest zero
    input  logic [S_TUSER_W-1:0] s_tuser,   // [0] new_graph, [1] has_neighbor
    input  logic                 s_tlast,   // last_of_node
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,   // [9:0] node_index, [14:10] node_color,
                                            // [20:15] colors_used, rest zero
    input  logic                 m_tuser,   // color_overflow
    output int                   fail_count,
    output int                   pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // result word layout
    localparam int unsigned COL_LSB  = OUT_NODE_W;
    localparam int unsigned USED_LSB = COL_LSB + OUT_COL_W;
    localparam int unsigned PAD_LSB  = USED_LSB + OUT_USED_W;

    typedef struct packed {
        logic [OUT_NODE_W-1:0] node;
        logic [OUT_COL_W-1:0]  colour;
        logic [OUT_USED_W-1:0] used;
        logic                  overflow;
    } colouring_t;

    // model state
    colouring_t                 expected_colourings[$];
    logic [OUT_COL_W-1:0]       colour_of[MAX_NODES_DEF];
    logic [MAX_COLORS_DEF-1:0]  blocked;
    logic [OUT_NODE_W-1:0]      node_now;
    logic [OUT_COL_W-1:0]       top_colour;

    initial begin
        fail_count    = 0;
        pending_count = 0;
    end

    // one line per mismatch
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        fail_count++;
    endtask

    // fold one input word into the model, queue a colouring on the last word
    task automatic colour_word(input item_t w);
        colouring_t           r;
        logic [OUT_COL_W-1:0] pick;
        logic                 ovf;
        int                   c;
        if (w.new_graph) begin
            node_now   = '0;
            top_colour = '0;
            blocked    = '0;
        end
        // only lower-numbered neighbours count, those entries are written
        if (w.has_neighbor && w.neighbor_index < node_now) begin
            blocked[colour_of[w.neighbor_index]] = 1'b1;
        end
        if (w.last_of_node) begin
            // lowest free colour, saturating at the top one
            pick = OUT_COL_W'(MAX_COLORS_DEF - 1);
            ovf  = 1'b1;
            for (c = MAX_COLORS_DEF - 1; c >= 0; c--) begin
                if (!blocked[c]) begin
                    pick = OUT_COL_W'(c);
                    ovf  = 1'b0;
                end
            end
            colour_of[node_now] = pick;
            if (pick > top_colour) begin
                top_colour = pick;
            end
            r.node     = node_now;
            r.colour   = pick;
            r.used     = OUT_USED_W'(top_colour) + 1'b1;
            r.overflow = ovf;
            expected_colourings = {expected_colourings, r};
            blocked  = '0;
            // node table is exactly 2^10 deep, so the counter wraps by itself
            node_now = node_now + 1'b1;
        end
    endtask

    // sample both channels at the clock edge
    always @(posedge aclk) begin : watch
        item_t      w;
        colouring_t want;
        if (!aresetn) begin
            node_now   = '0;
            top_colour = '0;
            blocked    = '0;
            expected_colourings.delete();
        end else begin
            // input word accepted
            if (s_tvalid && s_tready) begin
                w.new_graph      = s_tuser[S_USER_NEW_GRAPH];
                w.has_neighbor   = s_tuser[S_USER_HAS_NB];
                w.neighbor_index = s_tdata[NB_W-1:0];
                w.last_of_node   = s_tlast;
                colour_word(w);
            end
            // result word accepted
            if (m_tvalid && m_tready) begin
                if (expected_colourings.size() == 0) begin
                    report_mismatch("result word with nothing pending", m_tdata, '0);
                end else begin
                    want = expected_colourings.pop_front();
                    if (m_tdata[COL_LSB-1:0] !== want.node)
                        report_mismatch("node_index", m_tdata[COL_LSB-1:0], want.node);
                    if (m_tdata[USED_LSB-1:COL_LSB] !== want.colour)
                        report_mismatch("node_color", m_tdata[USED_LSB-1:COL_LSB], want.colour);
                    if (m_tdata[PAD_LSB-1:USED_LSB] !== want.used)
                        report_mismatch("colors_used", m_tdata[PAD_LSB-1:USED_LSB], want.used);
                    if (m_tdata[M_TDATA_W-1:PAD_LSB] !== '0)
                        report_mismatch("tdata padding", m_tdata[M_TDATA_W-1:PAD_LSB], '0);
                    if (m_tuser !== want.overflow)
                        report_mismatch("color_overflow", m_tuser, want.overflow);
                end
            end
        end
        pending_count = expected_colourings.size();
    end

endmodule

/* bench/greedy_first_fit_coloring_tb.sv */
// ----------------------------------------------------------------------------
// greedy first-fit colouring testbench
// Drives neighbour words into the colouring block: a short directed start, a
// full clique that saturates every colour, then random graphs with random
// gaps on both channels, one long result stall and pauses until all
// colourings are out. The checker beside the block predicts and compares;
// this module gives the verdict.
// ----------------------------------------------------------------------------
module greedy_first_fit_coloring_tb;
    import gffc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT  = 2000;  // cycles without any accepted word
    localparam int HOLD_CYCLES  = 300;   // long result stall
    localparam int RANDOM_WORDS = 130;
    localparam int CLIQUE_NODES = MAX_COLORS_DEF + 2;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // [9:0] neighbor_index, rest zero
    logic [S_TUSER_W-1:0] s_tuser;   // [0] new_graph, [1] has_neighbor
    logic                 s_tlast;   // last_of_node
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // [9:0] node_index, [14:10] node_color,
                                     // [20:15] colors_used, rest zero
    logic                 m_tuser;   // color_overflow

    int fail_count;
    int pending_count;

    // stimulus bookkeeping
    bit idle_on  = 1'b1;
    bit hold_req = 1'b0;
    int node_now = 0;
    int words_sent, graphs_started;
    int results_seen, overflow_seen, peak_used;

    greedy_first_fit_coloring dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    greedy_first_fit_coloring_checker chk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // send one word, after a random gap, and wait for its acceptance
    task automatic send_word(input bit ng, input bit hn, input int idx, input bit last);
        int                   gap;
        bit                   took;
        logic [NB_W-1:0]      nb;
        logic [S_TUSER_W-1:0] user;
        gap  = idle_on ? $urandom_range(0, 6) : 0;
        nb   = idx[NB_W-1:0];
        user = '0;
        user[S_USER_NEW_GRAPH] = ng;
        user[S_USER_HAS_NB]    = hn;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(nb);
        s_tuser  <= user;
        s_tlast  <= last;
        do begin
            @(negedge aclk);
            took = s_tready;
            @(posedge aclk);
        end while (!took);
        // track the node being fed, for choosing neighbours
        words_sent++;
        if (ng) begin
            node_now = 0;
            graphs_started++;
        end
        if (last) node_now = (node_now + 1) % MAX_NODES_DEF;
    endtask

    // stop sending until every colouring has come out
    task automatic drain_results;
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending_count != 0);
        @(posedge aclk);
    endtask

    // mostly recent lower nodes, so colours climb; some ignored indices
    function automatic int pick_neighbor();
        int r;
        r = $urandom_range(0, 9);
        if (node_now == 0 || r == 9) return $urandom_range(0, MAX_NODES_DEF - 1);
        if (r == 8) return node_now;
        if (r >= 6) return $urandom_range(0, node_now - 1);
        return node_now - 1 - $urandom_range(0, (node_now > 8) ? 7 : node_now - 1);
    endfunction

    // one node: a lone empty word or a run of neighbour words
    task automatic send_node(input bit ng_first);
        int n, k, idx;
        bit ng, hn;
        if ($urandom_range(0, 4) == 0) n = 0;
        else if ($urandom_range(0, 9) == 0) n = $urandom_range(9, 24);
        else n = $urandom_range(1, 8);
        if (n == 0) begin
            send_word(ng_first, 1'b0, $urandom_range(0, MAX_NODES_DEF - 1), 1'b1);
        end else begin
            for (k = 0; k < n; k++) begin
                // rare restart in the middle of a node
                ng  = (k == 0) ? ng_first : ($urandom_range(0, 59) == 0);
                hn  = ($urandom_range(0, 11) != 0);
                idx = hn ? pick_neighbor() : $urandom_range(0, MAX_NODES_DEF - 1);
                send_word(ng, hn, idx, k == n - 1);
            end
        end
    endtask

    // result side: random readiness, one long hold-off on request
    initial begin : result_sink
        int gap;
        bit got;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end
            gap = idle_on ? $urandom_range(0, 6) : 0;
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do begin
                @(negedge aclk);
                got = m_tvalid;
                if (got) begin
                    results_seen++;
                    if (m_tuser) overflow_seen++;
                    if (int'(m_tdata[OUT_NODE_W+OUT_COL_W +: OUT_USED_W]) > peak_used)
                        peak_used = int'(m_tdata[OUT_NODE_W+OUT_COL_W +: OUT_USED_W]);
                end
                @(posedge aclk);
            end while (!got);
        end
    end

    // watchdog on cycles with no accepted word
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        forever begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("no word moved for %0d cycles, %0d colourings outstanding",
                         STALL_LIMIT, pending_count);
                $display("FAIL greedy_first_fit_coloring");
                $finish;
            end
        end
    end

    // stimulus and verdict
    initial begin : stimulus
        int k, j, g, n, start;
        bit fresh;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        s_tlast  <= 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed start
        send_word(1, 0, 1023, 1);        // node 0, no neighbour, index bits all high
        send_word(0, 1, 0, 0);           // node 1: neighbour just written
        send_word(0, 1, 1, 1);           // itself, ignored
        send_word(0, 1, 1023, 0);        // node 2: above, ignored
        send_word(0, 1, 0, 0);
        send_word(0, 1, 1, 0);
        send_word(0, 0, 0, 1);           // empty last word
        send_word(0, 1, 2, 0);           // node 3: only colour 2 blocked
        send_word(0, 0, 682, 1);
        send_word(0, 1, 3, 0);           // node 4: repeated colour among neighbours
        send_word(0, 1, 0, 0);
        send_word(0, 1, 2, 1);
        send_word(0, 1, 4, 1);           // node 5: single-word node
        send_word(0, 1, 4, 0);           // restart in the middle of a node
        send_word(1, 1, 0, 0);
        send_word(0, 1, 341, 1);
        drain_results;

        // clique: colours climb to the top, then saturate
        idle_on = ($urandom_range(0, 1) != 0);
        for (k = 0; k < CLIQUE_NODES; k++) begin
            if (k == 0) begin
                send_word(1, 0, $urandom_range(0, MAX_NODES_DEF - 1), 1);
            end else begin
                for (j = 0; j < k; j++)
                    send_word(0, 1, k - 1 - j, j == k - 1);
            end
        end
        send_word(0, 0, 0, 1);
        drain_results;

        // random graphs
        start = words_sent;
        g     = 0;
        while (words_sent - start < RANDOM_WORDS) begin
            idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 7) == 0) n = $urandom_range(15, 25);
            else n = $urandom_range(1, 10);
            if (g == 0) begin
                // result side stalls while words keep coming
                hold_req = 1'b1;
                n        = 12;
            end
            fresh = (g == 0) || ($urandom_range(0, 5) != 0);
            for (k = 0; k < n; k++) send_node(fresh && k == 0);
            if ($urandom_range(0, 2) == 0) drain_results;
            g++;
        end

        // wait for the tail, then give the verdict
        drain_results;
        repeat (8) @(posedge aclk);
        $display("covered %0d words in %0d graphs, %0d colourings, up to %0d colours in use",
                 words_sent, graphs_started, results_seen, peak_used);
        $display("%0d saturated colourings, one long result stall, gaps on both sides",
                 overflow_seen);
        if (fail_count == 0 && pending_count == 0) begin
            $display("PASS greedy_first_fit_coloring");
        end else begin
            $display("FAIL greedy_first_fit_coloring");
        end
        $finish;
    end

endmodule
